>>> sv/ecc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types and codes for the elliptic-curve ElGamal point cipher.
// ----------------------------------------------------------------------------
package ecc_pkg;

  localparam int unsigned CoordBits = 10;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    logic   operation;
    coord_t in_a_x;
    coord_t in_a_y;
    coord_t in_b_x;
    coord_t in_b_y;
    coord_t nonce;
  } in_item_t;

  typedef struct packed {
    coord_t out_a_x;
    coord_t out_a_y;
    coord_t out_b_x;
    coord_t out_b_y;
  } out_item_t;

  localparam logic [2:0] RegCurveA  = 3'd0;
  localparam logic [2:0] RegModulus = 3'd1;
  localparam logic [2:0] RegGenX    = 3'd2;
  localparam logic [2:0] RegGenY    = 3'd3;
  localparam logic [2:0] RegPrivKey = 3'd4;

  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  // Modular unit operations.
  localparam logic [1:0] MopReduce = 2'd0;
  localparam logic [1:0] MopMul    = 2'd1;
  localparam logic [1:0] MopInv    = 2'd2;

  // Point-operation commands to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE  = 4'd0,
    CMD_LOAD  = 4'd1,  // reduce inputs and config into working registers
    CMD_SMUL  = 4'd2,  // acc = scal * run
    CMD_ADD   = 4'd3,  // acc = opa + opb
    CMD_DONE  = 4'd4
  } cmd_t;

  // Operand sources for a scalar multiply / point add.
  typedef enum logic [2:0] {
    SRC_G   = 3'd0,
    SRC_PA  = 3'd1,
    SRC_PB  = 3'd2,
    SRC_T0  = 3'd3,
    SRC_T1  = 3'd4,
    SRC_NEG = 3'd5,
    SRC_INF = 3'd6
  } src_t;

  typedef enum logic [1:0] {
    SCL_D    = 2'd0,
    SCL_K    = 2'd1
  } scl_t;

  typedef enum logic [1:0] {
    DST_T0 = 2'd0,
    DST_T1 = 2'd1,
    DST_R1 = 2'd2,
    DST_R2 = 2'd3
  } dst_t;

  typedef struct packed {
    logic start;
    cmd_t cmd;
    src_t src_a;
    src_t src_b;
    scl_t scl;
    dst_t dst;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_sts_t;

endpackage

>>> sv/ecc_modu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_modu
// Modular arithmetic unit: reduce, multiply and extended Euclid inverse,
// one shift-subtract step per cycle.
// ----------------------------------------------------------------------------
module ecc_modu #(
  parameter int unsigned CB = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    op,     // 0 reduce(a), 1 a*b mod p, 2 inverse(a)
  input  logic [CB-1:0] a,
  input  logic [CB-1:0] b,
  input  logic [CB-1:0] p,
  output logic          busy,
  output logic [CB-1:0] res
);
  import ecc_pkg::*;

  localparam int unsigned WW = 2 * CB + 1;
  localparam int unsigned SW = 2 * CB + 2;
  localparam int unsigned CW = $clog2(2 * CB + 2);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_RED  = 4'b0010,
    M_EUC  = 4'b0100,
    M_FIN  = 4'b1000
  } mst_t;

  mst_t            st;
  logic [WW-1:0]   rem;
  logic [WW-1:0]   dvs;
  logic [CW-1:0]   cnt;
  logic [1:0]      opr;
  // Euclid registers: r, nr unsigned; t, nt signed.
  logic [CB-1:0]   er, enr;
  logic signed [SW-1:0] et, ent;
  // Euclid division: quotient by shift-subtract over sh.
  logic [CB-1:0]   qr;         // remainder being reduced
  logic signed [SW-1:0] tacc;  // t - q*nt accumulated
  logic [CB-1:0]   dshift;
  logic signed [SW-1:0] nshift;
  logic [CW-1:0]   sh;
  logic            indiv;
  logic [WW-1:0]   prod;

  assign prod = WW'(a) * WW'(b);
  assign busy = (st != M_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= M_IDLE;
    end else begin
      unique case (st)
        M_IDLE: begin
          if (start) begin
            opr <= op;
            if (op == MopInv) begin
              er    <= p;
              enr   <= a;
              et    <= '0;
              ent   <= SW'(1);
              indiv <= 1'b0;
              st    <= M_EUC;
            end else begin
              rem <= (op == MopMul) ? prod : WW'(a);
              dvs <= WW'(p) << CB;
              cnt <= CW'(CB);
              st  <= M_RED;
            end
          end
        end
        M_RED: begin
          // one restoring-division step per cycle
          if (rem >= dvs) rem <= rem - dvs;
          dvs <= dvs >> 1;
          if (cnt == '0) st <= M_FIN;
          else cnt <= cnt - 1'b1;
        end
        M_EUC: begin
          if (!indiv) begin
            if (enr == '0) begin
              st <= M_FIN;
            end else begin
              // align divisor under remainder, largest shift first
              qr     <= er;
              tacc   <= et;
              dshift <= enr;
              nshift <= ent;
              sh     <= '0;
              indiv  <= 1'b1;
            end
          end else if ((dshift[CB-1] == 1'b0) && ({dshift, 1'b0} <= {1'b0, qr})) begin
            dshift <= dshift << 1;
            nshift <= nshift <<< 1;
            sh     <= sh + 1'b1;
          end else begin
            if (qr >= dshift) begin
              qr   <= qr - dshift;
              tacc <= tacc - nshift;
            end
            dshift <= dshift >> 1;
            nshift <= nshift >>> 1;
            if (sh == '0) begin
              indiv <= 1'b0;
              er    <= enr;
              et    <= ent;
              enr   <= (qr >= dshift) ? qr - dshift : qr;
              ent   <= (qr >= dshift) ? tacc - nshift : tacc;
            end else begin
              sh <= sh - 1'b1;
            end
          end
        end
        M_FIN: begin
          if (opr == MopInv) begin
            if (er > CB'(1)) res <= p - CB'(1);
            else if (et < 0) res <= CB'(et + $signed({2'b00, p}));
            else res <= CB'(et);
          end else begin
            res <= rem[CB-1:0];
          end
          st <= M_IDLE;
        end
        default: st <= M_IDLE;
      endcase
    end
  end
endmodule

>>> sv/ecc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_dpath
// Point datapath: working points, scalar multiply sequencing over point add
// and double, field multiplies, reductions and inverses through one shared modular unit.
// ----------------------------------------------------------------------------
module ecc_dpath #(
  parameter int unsigned CB = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  ecc_pkg::dp_cmd_t  cmd,
  input  ecc_pkg::in_item_t item,
  input  logic [CB-1:0]     cfg_a,
  input  logic [CB-1:0]     cfg_p,
  input  logic [CB-1:0]     cfg_gx,
  input  logic [CB-1:0]     cfg_gy,
  input  logic [CB-1:0]     cfg_d,
  output ecc_pkg::dp_sts_t  sts,
  output ecc_pkg::out_item_t res
);
  import ecc_pkg::*;

  localparam int unsigned BW = $clog2(CB + 1);

  typedef enum logic [17:0] {
    P_IDLE = 18'd1 << 0,
    P_LD   = 18'd1 << 1,
    P_LDW  = 18'd1 << 2,
    P_BIT  = 18'd1 << 3,
    P_ADD  = 18'd1 << 4,   // start point add acc+run or opa+opb
    P_DBL  = 18'd1 << 5,
    P_M1   = 18'd1 << 6,   // field op issue
    P_W1   = 18'd1 << 7,
    P_M2   = 18'd1 << 8,
    P_W2   = 18'd1 << 9,
    P_M3   = 18'd1 << 10,
    P_W3   = 18'd1 << 11,
    P_M4   = 18'd1 << 12,
    P_W4   = 18'd1 << 13,
    P_PEND = 18'd1 << 14,
    P_STO  = 18'd1 << 15,
    P_M0   = 18'd1 << 16,
    P_W0   = 18'd1 << 17
  } pst_t;

  pst_t          st;
  logic [CB-1:0] p;
  logic [CB-1:0] ca;
  logic [CB-1:0] gx, gy, pax, pay, pbx, pby, t0x, t0y, t1x, t1y;
  logic [CB-1:0] scal;
  logic [BW-1:0] bi;
  logic          in_smul, is_dbl, ld_op;
  dst_t          dst;
  logic [2:0]    ldi;
  // point operation operands and result
  logic [CB-1:0] ux, uy, vx, vy, rx, ry, m, tq;
  logic [CB-1:0] accx, accy, runx, runy;
  // modular unit
  logic          mstart;
  logic [1:0]    mop;
  logic [CB-1:0] ma, mb, mres;
  logic          mbusy;

  ecc_modu #(.CB(CB)) u_modu (
    .clk(clk), .rst(rst), .start(mstart), .op(mop), .a(ma), .b(mb), .p(p),
    .busy(mbusy), .res(mres)
  );

  function automatic logic [CB-1:0] fadd(logic [CB-1:0] x, logic [CB-1:0] y,
                                         logic [CB-1:0] q);
    logic [CB:0] s;
    s = {1'b0, x} + {1'b0, y};
    return (s >= {1'b0, q}) ? CB'(s - {1'b0, q}) : s[CB-1:0];
  endfunction

  function automatic logic [CB-1:0] fsub(logic [CB-1:0] x, logic [CB-1:0] y,
                                         logic [CB-1:0] q);
    return (x >= y) ? x - y : x + (q - y);
  endfunction

  function automatic logic [CB-1:0] pick_x(src_t s, logic [CB-1:0] g, logic [CB-1:0] a,
                                           logic [CB-1:0] b, logic [CB-1:0] t0,
                                           logic [CB-1:0] t1);
    unique case (s)
      SRC_G:   return g;
      SRC_PA:  return a;
      SRC_PB:  return b;
      SRC_T0:  return t0;
      SRC_T1:  return t1;
      default: return '0;
    endcase
  endfunction

  assign sts.busy = (st != P_IDLE);

  logic [CB-1:0] negy;
  assign negy = (t0y == '0) ? '0 : p - t0y;

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= P_IDLE;
      mstart <= 1'b0;
    end else begin
      mstart <= 1'b0;
      unique case (st)
        P_IDLE: begin
          if (cmd.start) begin
            dst <= cmd.dst;
            unique case (cmd.cmd)
              CMD_LOAD: begin
                p   <= (cfg_p < CB'(3)) ? CB'(3) : cfg_p;
                ldi <= '0;
                st  <= P_LD;
              end
              CMD_SMUL: begin
                in_smul <= 1'b1;
                accx <= '0; accy <= '0;
                runx <= pick_x(cmd.src_a, gx, pax, pbx, t0x, t1x);
                runy <= pick_x(cmd.src_a, gy, pay, pby, t0y, t1y);
                scal <= (cmd.scl == SCL_D) ? cfg_d : item.nonce;
                bi   <= '0;
                st   <= P_BIT;
              end
              CMD_ADD: begin
                in_smul <= 1'b0;
                ux <= pick_x(cmd.src_a, gx, pax, pbx, t0x, t1x);
                uy <= pick_x(cmd.src_a, gy, pay, pby, t0y, t1y);
                vx <= (cmd.src_b == SRC_NEG) ? t0x : pick_x(cmd.src_b, gx, pax, pbx, t0x, t1x);
                vy <= (cmd.src_b == SRC_NEG) ? negy
                                             : pick_x(cmd.src_b, gy, pay, pby, t0y, t1y);
                st <= P_ADD;
              end
              CMD_DONE: begin
                res.out_a_x <= t1x;
                res.out_a_y <= t1y;
                res.out_b_x <= (item.operation == OpDecrypt) ? '0 : t0x;
                res.out_b_y <= (item.operation == OpDecrypt) ? '0 : t0y;
              end
              default: ;
            endcase
          end
        end
        // reduce the seven inputs one after another
        P_LD: begin
          mstart <= 1'b1;
          mop    <= MopReduce;
          unique case (ldi)
            3'd0: ma <= cfg_a;
            3'd1: ma <= cfg_gx;
            3'd2: ma <= cfg_gy;
            3'd3: ma <= item.in_a_x;
            3'd4: ma <= item.in_a_y;
            3'd5: ma <= item.in_b_x;
            default: ma <= item.in_b_y;
          endcase
          st <= P_LDW;
        end
        P_LDW: begin
          if (!mstart && !mbusy) begin
            unique case (ldi)
              3'd0: ca  <= mres;
              3'd1: gx  <= mres;
              3'd2: gy  <= mres;
              3'd3: pax <= mres;
              3'd4: pay <= mres;
              3'd5: pbx <= mres;
              default: pby <= mres;
            endcase
            if (ldi == 3'd6) st <= P_IDLE;
            else begin
              ldi <= ldi + 1'b1;
              st  <= P_LD;
            end
          end
        end
        P_BIT: begin
          if (bi == BW'(CB)) begin
            st <= P_STO;
          end else if (scal[0]) begin
            ux <= accx; uy <= accy; vx <= runx; vy <= runy;
            st <= P_ADD;
          end else begin
            st <= P_DBL;
          end
        end
        P_DBL: begin
          ux <= runx; uy <= runy;
          is_dbl <= 1'b1;
          ld_op  <= 1'b0;
          if (runy == '0) begin
            rx <= '0; ry <= '0; st <= P_PEND;
          end else st <= P_M0;
        end
        P_ADD: begin
          ld_op <= 1'b1;
          if (ux == '0 && uy == '0) begin
            rx <= vx; ry <= vy; st <= P_PEND;
          end else if (vx == '0 && vy == '0) begin
            rx <= ux; ry <= uy; st <= P_PEND;
          end else if (ux == vx) begin
            if (uy == vy && uy != '0) begin
              is_dbl <= 1'b1; st <= P_M0;
            end else begin
              rx <= '0; ry <= '0; st <= P_PEND;
            end
          end else begin
            is_dbl <= 1'b0; st <= P_M1;
          end
        end
        // doubling numerator: x*x
        P_M0: begin
          mstart <= 1'b1; mop <= MopMul; ma <= ux; mb <= ux; st <= P_W0;
        end
        P_W0: if (!mstart && !mbusy) begin
          tq <= fadd(fadd(fadd(mres, mres, p), mres, p), ca, p);
          st <= P_M1;
        end
        // inverse of denominator
        P_M1: begin
          mstart <= 1'b1; mop <= MopInv;
          ma <= is_dbl ? fadd(uy, uy, p) : fsub(vx, ux, p);
          if (!is_dbl) tq <= fsub(vy, uy, p);
          st <= P_W1;
        end
        P_W1: if (!mstart && !mbusy) st <= P_M2;
        P_M2: begin
          mstart <= 1'b1; mop <= MopMul; ma <= tq; mb <= mres; st <= P_W2;
        end
        P_W2: if (!mstart && !mbusy) begin
          m <= mres; st <= P_M3;
        end
        P_M3: begin
          mstart <= 1'b1; mop <= MopMul; ma <= m; mb <= m; st <= P_W3;
        end
        P_W3: if (!mstart && !mbusy) begin
          rx <= is_dbl ? fsub(mres, fadd(ux, ux, p), p) : fsub(fsub(mres, ux, p), vx, p);
          st <= P_M4;
        end
        P_M4: begin
          mstart <= 1'b1; mop <= MopMul; ma <= m; mb <= fsub(ux, rx, p); st <= P_W4;
        end
        P_W4: if (!mstart && !mbusy) begin
          ry <= fsub(mres, uy, p); st <= P_PEND;
        end
        P_PEND: begin
          if (!in_smul) st <= P_STO;
          else if (ld_op) begin
            // finished acc + run, now double run
            accx <= rx; accy <= ry; st <= P_DBL;
          end else begin
            runx <= rx; runy <= ry;
            scal <= scal >> 1; bi <= bi + 1'b1; st <= P_BIT;
          end
        end
        P_STO: begin
          unique case (dst)
            DST_T0: begin t0x <= in_smul ? accx : rx; t0y <= in_smul ? accy : ry; end
            DST_T1: begin t1x <= in_smul ? accx : rx; t1y <= in_smul ? accy : ry; end
            default: ;
          endcase
          st <= P_IDLE;
        end
        default: st <= P_IDLE;
      endcase
    end
  end
endmodule

>>> sv/ecc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_ctrl
// Sequencer: issues the point-level commands for encrypt and decrypt.
// ----------------------------------------------------------------------------
module ecc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             operation,
  input  logic             out_ready,
  input  ecc_pkg::dp_sts_t sts,
  output logic             in_ready,
  output logic             out_valid,
  output ecc_pkg::dp_cmd_t cmd
);
  import ecc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LOAD = 9'b000000010,
    S_DG   = 9'b000000100,  // T0 = d*G           | T0 = d*C1
    S_KDG  = 9'b000001000,  // T0 = k*T0          | T1 = C2 + (-T0)
    S_KG   = 9'b000010000,  // T1 = k*G
    S_ADD  = 9'b000100000,  // T0 = M + T0
    S_OUT  = 9'b001000000,
    S_WAIT = 9'b010000000,
    S_HOLD = 9'b100000000
  } cst_t;

  cst_t st, nxt;
  logic op;
  logic issued;

  assign in_ready = (st == S_IDLE);
  assign out_valid = (st == S_HOLD);

  always_comb begin
    cmd = '{start: 1'b0, cmd: CMD_NONE, src_a: SRC_G, src_b: SRC_G, scl: SCL_D,
            dst: DST_T0};
    unique case (st)
      S_LOAD: cmd.cmd = CMD_LOAD;
      S_DG: begin
        cmd.cmd = CMD_SMUL;
        cmd.src_a = (op == OpDecrypt) ? SRC_PA : SRC_G;
      end
      S_KDG: begin
        if (op == OpDecrypt) begin
          cmd.cmd = CMD_ADD; cmd.src_a = SRC_PB; cmd.src_b = SRC_NEG; cmd.dst = DST_T1;
        end else begin
          cmd.cmd = CMD_SMUL; cmd.src_a = SRC_T0; cmd.scl = SCL_K;
        end
      end
      S_KG: begin
        cmd.cmd = CMD_SMUL; cmd.scl = SCL_K; cmd.dst = DST_T1;
      end
      S_ADD: begin
        cmd.cmd = CMD_ADD; cmd.src_a = SRC_PA; cmd.src_b = SRC_T0;
      end
      S_OUT: cmd.cmd = CMD_DONE;
      default: ;
    endcase
    cmd.start = !issued && (st != S_IDLE) && (st != S_WAIT) && (st != S_HOLD) &&
                !sts.busy;
  end

  always_comb begin
    nxt = st;
    unique case (st)
      S_IDLE: if (in_valid) nxt = S_LOAD;
      S_LOAD: if (issued && !sts.busy) nxt = S_DG;
      S_DG:   if (issued && !sts.busy) nxt = S_KDG;
      S_KDG:  if (issued && !sts.busy) nxt = (op == OpDecrypt) ? S_OUT : S_KG;
      S_KG:   if (issued && !sts.busy) nxt = S_ADD;
      S_ADD:  if (issued && !sts.busy) nxt = S_OUT;
      S_OUT:  if (issued) nxt = S_WAIT;
      S_WAIT: nxt = S_HOLD;
      S_HOLD: if (out_ready) nxt = S_IDLE;
      default: nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= S_IDLE;
      issued <= 1'b0;
    end else begin
      st <= nxt;
      if (nxt != st) issued <= 1'b0;
      else if (cmd.start) issued <= 1'b1;
      if (st == S_IDLE && in_valid) op <= operation;
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output both open");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_idle_dp: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !sts.busy) else $error("datapath busy while idle");
endmodule

>>> sv/ecc_elgamal_point_cipher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_elgamal_point_cipher_unit
// Elliptic-curve ElGamal encrypt/decrypt over a small prime field.
// ----------------------------------------------------------------------------
// One transaction at a time. Encrypt runs three scalar multiplies (d*G, k*dG,
// k*G) and one point add; decrypt runs one scalar multiply and one add. Each
// point op goes through a single shared modular unit, for its multiplies and
// inverses alike.
// Configuration writes are taken only while the block is idle.
module ecc_elgamal_point_cipher_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ecc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ecc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  ecc_pkg::coord_t    cfg_data
);
  import ecc_pkg::*;

  coord_t curve_a, modulus, gen_x, gen_y, private_key;
  in_item_t item;
  dp_cmd_t  cmd;
  dp_sts_t  sts;

  // take a write only with nothing in flight and no transaction arriving
  assign cfg_ready = in_ready && !in_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_a     <= coord_t'(2);
      modulus     <= coord_t'(521);
      gen_x       <= coord_t'(3);
      gen_y       <= coord_t'(6);
      private_key <= coord_t'(15);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegCurveA:  curve_a     <= cfg_data;
        RegModulus: modulus     <= cfg_data;
        RegGenX:    gen_x       <= cfg_data;
        RegGenY:    gen_y       <= cfg_data;
        RegPrivKey: private_key <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold the accepted transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item <= in_data;
  end

  ecc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .operation(in_data.operation),
    .out_ready(out_ready), .sts(sts), .in_ready(in_ready), .out_valid(out_valid),
    .cmd(cmd)
  );

  ecc_dpath #(.CB(CoordBits)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .item(item), .cfg_a(curve_a), .cfg_p(modulus),
    .cfg_gx(gen_x), .cfg_gy(gen_y), .cfg_d(private_key), .sts(sts), .res(out_data)
  );

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data)) else $error("result changed");
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accepted while result pending");
  a_dec_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && item.operation == OpDecrypt |-> out_data.out_b_x == '0)
    else $error("decrypt second point not zero");
endmodule

>>> dv/ecc_elgamal_point_cipher_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_elgamal_point_cipher_checker
// Watches the config, input and output channels of the point cipher, keeps
// its own copy of the registers, predicts each result and compares.
// ----------------------------------------------------------------------------
module ecc_elgamal_point_cipher_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  ecc_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  ecc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  ecc_pkg::coord_t    cfg_data,
  output int                 pending,
  output int                 fails
);
  import ecc_pkg::*;

  typedef struct {
    longint x;
    longint y;
  } ec_point_t;

  coord_t    curve_a_q, modulus_q, gen_x_q, gen_y_q, priv_key_q;
  out_item_t cipher_q[$];

  function automatic longint field_inverse(longint v, longint p);
    longint t, nt, r, nr, q, tmp;
    t = 0; nt = 1; r = p; nr = v % p;
    while (nr != 0) begin
      q = r / nr;
      tmp = t; t = nt; nt = tmp - q * nt;
      tmp = r; r = nr; nr = tmp - q * nr;
    end
    if (r > 1) return p - 1;
    if (t < 0) t += p;
    return t % p;
  endfunction

  function automatic ec_point_t point_twice(ec_point_t u, longint p);
    ec_point_t r;
    longint num, m;
    r.x = 0; r.y = 0;
    if (u.y == 0) return r;
    num = (3 * ((u.x * u.x) % p) + (curve_a_q % p)) % p;
    m = (num * field_inverse((2 * u.y) % p, p)) % p;
    r.x = ((m * m) % p + p - (2 * u.x) % p) % p;
    r.y = ((m * ((u.x + p - r.x) % p)) % p + p - u.y) % p;
    return r;
  endfunction

  function automatic ec_point_t point_sum(ec_point_t u, ec_point_t v, longint p);
    ec_point_t r;
    longint m;
    r.x = 0; r.y = 0;
    // Infinity checks come ahead of the equal-x test.
    if (u.x == 0 && u.y == 0) return v;
    if (v.x == 0 && v.y == 0) return u;
    if (u.x == v.x) begin
      if (u.y == v.y) return point_twice(u, p);
      return r;
    end
    m = (((v.y + p - u.y) % p) * field_inverse((v.x + p - u.x) % p, p)) % p;
    r.x = (((m * m) % p + p - u.x) % p + p - v.x) % p;
    r.y = ((m * ((u.x + p - r.x) % p)) % p + p - u.y) % p;
    return r;
  endfunction

  // LSB-first double-and-add over all scalar bits.
  function automatic ec_point_t point_scale(ec_point_t u, coord_t k, longint p);
    ec_point_t acc, run;
    acc.x = 0; acc.y = 0;
    run = u;
    for (int i = 0; i < CoordBits; i++) begin
      if (k[i]) acc = point_sum(acc, run, p);
      run = point_twice(run, p);
    end
    return acc;
  endfunction

  function automatic out_item_t cipher_result(in_item_t it);
    out_item_t res;
    longint p;
    ec_point_t pa, pb, g, r1, r2, dg, dc1;
    p = (modulus_q < 3) ? 3 : modulus_q;
    pa.x = it.in_a_x % p; pa.y = it.in_a_y % p;
    pb.x = it.in_b_x % p; pb.y = it.in_b_y % p;
    g.x = gen_x_q % p;    g.y = gen_y_q % p;
    if (it.operation == OpEncrypt) begin
      dg = point_scale(g, priv_key_q, p);
      r1 = point_scale(g, it.nonce, p);
      r2 = point_sum(pa, point_scale(dg, it.nonce, p), p);
    end else begin
      dc1 = point_scale(pa, priv_key_q, p);
      dc1.y = (p - dc1.y) % p;
      r1 = point_sum(pb, dc1, p);
      r2.x = 0; r2.y = 0;
    end
    res.out_a_x = coord_t'(r1.x);
    res.out_a_y = coord_t'(r1.y);
    res.out_b_x = coord_t'(r2.x);
    res.out_b_y = coord_t'(r2.y);
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      curve_a_q  <= 10'd2;
      modulus_q  <= 10'd521;
      gen_x_q    <= 10'd3;
      gen_y_q    <= 10'd6;
      priv_key_q <= 10'd15;
      cipher_q.delete();
      pending <= 0;
      fails   <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegCurveA:  curve_a_q  <= cfg_data;
          RegModulus: modulus_q  <= cfg_data;
          RegGenX:    gen_x_q    <= cfg_data;
          RegGenY:    gen_y_q    <= cfg_data;
          RegPrivKey: priv_key_q <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) cipher_q.push_back(cipher_result(in_data));
      if (out_valid && out_ready) begin
        if (cipher_q.size() == 0) begin
          if (fails < 10) $display("%0t: unexpected result %h", $realtime, out_data);
          fails <= fails + 1;
        end else begin
          want = cipher_q.pop_front();
          if (out_data.out_a_x !== want.out_a_x || out_data.out_a_y !== want.out_a_y ||
              out_data.out_b_x !== want.out_b_x || out_data.out_b_y !== want.out_b_y) begin
            if (fails < 10)
              $display("%0t: mismatch exp a=(%0d,%0d) b=(%0d,%0d) got a=(%0d,%0d) b=(%0d,%0d)",
                       $realtime, want.out_a_x, want.out_a_y, want.out_b_x, want.out_b_y,
                       out_data.out_a_x, out_data.out_a_y, out_data.out_b_x,
                       out_data.out_b_y);
            fails <= fails + 1;
          end
        end
      end
      pending <= cipher_q.size();
    end
  end

endmodule

>>> dv/tb_ecc_elgamal_point_cipher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ecc_elgamal_point_cipher_unit
// Drives encrypt/decrypt transactions and register writes into the point
// cipher across several curve settings, with random stalls on both sides; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_ecc_elgamal_point_cipher_unit;
  import ecc_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid, in_ready;
  in_item_t  in_data;
  logic      out_valid, out_ready;
  out_item_t out_data;
  logic      cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  coord_t    cfg_data;
  int        pending, fails;
  int        field_p;   // modulus in force, for shaping well-formed operands
  bit        no_stall;  // stretches with the receiver always ready

  ecc_elgamal_point_cipher_unit i_dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  ecc_elgamal_point_cipher_checker i_checker (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .pending, .fails
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 400);
  endfunction

  // Receiver side: stall at random, except during no-stall stretches.
  initial begin
    int hold;
    out_ready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!no_stall) hold = idle_len();
      end
    end
  end

  // Hold valid and payload until the transaction is taken; valid drops only in a gap.
  task automatic send_item(in_item_t it);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_op(logic op, int ax, int ay, int bx, int by, int k);
    in_item_t it;
    it.operation = op;
    it.in_a_x = coord_t'(ax); it.in_a_y = coord_t'(ay);
    it.in_b_x = coord_t'(bx); it.in_b_y = coord_t'(by);
    it.nonce  = coord_t'(k);
    send_item(it);
  endtask

  // Drain: drop valid, wait for every result, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= coord_t'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == RegModulus) field_p = (val < 3) ? 3 : val;
  endtask

  task automatic set_curve(int a, int p, int gx, int gy, int d);
    drain();
    write_reg(RegCurveA, a);
    write_reg(RegModulus, p);
    write_reg(RegGenX, gx);
    write_reg(RegGenY, gy);
    write_reg(RegPrivKey, d);
  endtask

  // Mostly coordinates below the modulus, some full-width noise.
  function automatic int coord_pick();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, field_p - 1);
    return $urandom_range(0, 1023);
  endfunction

  task automatic random_items(int n);
    repeat (n) begin
      no_stall = ($urandom_range(0, 3) == 0);
      send_op(logic'($urandom_range(0, 1)), coord_pick(), coord_pick(),
              coord_pick(), coord_pick(), $urandom_range(0, 1023));
    end
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    field_p   = 521;
    no_stall  = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset curve, nonce extremes, infinity, coordinates above p.
    send_op(OpEncrypt, 5, 9, 0, 0, 0);
    send_op(OpEncrypt, 5, 9, 1023, 1023, 1);
    send_op(OpEncrypt, 0, 0, 0, 0, 1023);
    send_op(OpEncrypt, 1023, 1023, 0, 0, 77);
    send_op(OpDecrypt, 0, 0, 40, 50, 1023);
    send_op(OpDecrypt, 3, 6, 0, 0, 0);
    send_op(OpDecrypt, 1023, 1022, 1023, 1022, 5);
    // Hold off until the block has caught up.
    drain();
    send_op(OpDecrypt, 3, 6, 3, 515, 0);
    send_op(OpEncrypt, 12, 0, 0, 0, 3);
    // Non-prime modulus, extreme a and key.
    set_curve(1022, 1023, 1022, 1022, 1023);
    send_op(OpEncrypt, 4, 7, 0, 0, 1023);
    send_op(OpDecrypt, 11, 0, 1022, 1023, 0);
    // Modulus below 3 and zero key.
    set_curve(0, 0, 1, 1, 0);
    send_op(OpEncrypt, 2, 2, 0, 0, 5);
    send_op(OpDecrypt, 1, 2, 2, 1, 0);
    set_curve(1, 2, 1, 0, 1);
    send_op(OpEncrypt, 1, 1, 0, 0, 1023);
    send_op(OpDecrypt, 1, 1, 1, 2, 0);

    // Random phases over several curves.
    set_curve(0, 3, 1, 1, 1023);
    random_items(15);
    set_curve(2, 521, 3, 6, 15);
    random_items(25);
    set_curve(0, 1021, $urandom_range(0, 1020), $urandom_range(0, 1020),
              $urandom_range(0, 1023));
    random_items(25);
    set_curve($urandom_range(0, 1022), $urandom_range(3, 1023), $urandom_range(0, 1022),
              $urandom_range(0, 1022), $urandom_range(0, 1023));
    random_items(20);
    set_curve(7, 97, 1, 28, $urandom_range(0, 1023));
    random_items(15);

    drain();
    repeat (100) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Timeout, far beyond the slowest correct run.
  initial begin
    #(400_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
